>>> rtl/assert_macros.svh
// Assertion macros shared by the envelope gain RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define AEG_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Condition must hold in the cycle after the trigger.
`define AEG_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

// Condition must hold a fixed number of cycles after the trigger.
`define AEG_ASSERT_DELAY(name, pre, n, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> ##n (post)) \
    else $error("assertion failed");

`endif

>>> rtl/aeg_pkg.sv
// Shared types and constants of the ADSR envelope gain unit.
`default_nettype none

package aeg_pkg;

  // Field and datapath widths
  localparam int LEN_W       = 14;
  localparam int STEP_W      = 24;
  localparam int BND_W       = 16;
  localparam int PHASE_W     = 32;
  localparam int GAIN_W      = 16;
  localparam int QUO_W       = 15;
  localparam int NUM_W       = LEN_W + QUO_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int DIV_STEPS   = QUO_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  // Item queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Item mode codes on tuser
  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_TRIGGER = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  // Envelope stage codes
  localparam logic [2:0] STAGE_ATTACK   = 3'd0;
  localparam logic [2:0] STAGE_DECAY    = 3'd1;
  localparam logic [2:0] STAGE_SUSTAIN  = 3'd2;
  localparam logic [2:0] STAGE_RELEASE  = 3'd3;
  localparam logic [2:0] STAGE_FINISHED = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP    = 3'd4;

  // Register reset values
  localparam logic [LEN_W-1:0]  LEN_RESET  = 14'd1000;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd65536;

  // Q1.15 gains
  localparam logic [GAIN_W-1:0] GAIN_ONE        = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_SUSTAIN    = 16'd19661;
  localparam logic [GAIN_W-1:0] GAIN_DECAY_DROP = 16'd13107;

  // Classified queue item
  typedef enum logic [1:0] {
    KIND_SAMPLE,
    KIND_TRIGGER,
    KIND_RELEASE
  } item_kind_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG,
    ST_MUL,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } core_state_t;

  // Settings seen by the back end; bounds are running sums of lengths
  typedef struct packed {
    logic [LEN_W-1:0]  attack_len;
    logic [LEN_W-1:0]  decay_len;
    logic [LEN_W-1:0]  release_len;
    logic [STEP_W-1:0] phase_step;
    logic [BND_W-1:0]  bnd_a;
    logic [BND_W-1:0]  bnd_d;
    logic [BND_W-1:0]  bnd_s;
    logic [BND_W-1:0]  bnd_r;
  } env_cfg_t;

endpackage

`default_nettype wire

>>> rtl/aeg_div.sv
// Restoring divider, one quotient bit per cycle, for the ramp gains.
`default_nettype none
`include "assert_macros.svh"

module aeg_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [aeg_pkg::NUM_W-1:0]   num,
  input  wire logic [aeg_pkg::LEN_W-1:0]   den,
  output logic                             done,
  output logic [aeg_pkg::QUO_W-1:0]        quo
);
  import aeg_pkg::*;

  // start loads the operands, then each step makes one quotient bit; done is registered after the last
  localparam int DIV_LAT = DIV_STEPS + 1;

  logic [LEN_W-1:0]     rem_r, rem_nxt;
  logic [LEN_W-1:0]     den_r;
  logic [QUO_W-1:0]     low_r, low_nxt;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [LEN_W:0]       trial;
  logic                 fits;

  // one subtract-and-compare step
  always_comb begin
    trial   = {rem_r, low_r[QUO_W-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? LEN_W'(trial - {1'b0, den_r}) : LEN_W'(trial);
    low_nxt = {low_r[QUO_W-2:0], 1'b0};
    quo_nxt = {quo_r[QUO_W-2:0], fits};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath; quotient fits QUO_W bits so the top of num starts below den
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_W-1:QUO_W];
      low_r <= num[QUO_W-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  `AEG_ASSERT_DELAY(a_div_latency, start, DIV_LAT, done)
  `AEG_ASSERT_NEXT(a_div_no_restart, start, busy_r && !done_r)

endmodule

`default_nettype wire

>>> rtl/aeg_front.sv
// Input side: accepts items, classifies the mode and queues them.
`default_nettype none
`include "assert_macros.svh"

module aeg_front #(
  parameter  int SAMPLE_WIDTH = 16,
  localparam int IN_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [IN_TDATA_W-1:0]   in_tdata,   // sample_in
  input  wire logic [1:0]              in_tuser,   // mode
  input  wire logic                    in_tlast,   // end_of_block
  output logic                         q_valid,
  input  wire logic                    q_ready,
  output aeg_pkg::item_kind_t          q_kind,
  output logic [SAMPLE_WIDTH-1:0]      q_sample,
  output logic                         q_eob
);
  import aeg_pkg::*;

  localparam int EW = 2 + SAMPLE_WIDTH + 1;

  logic [EW-1:0]   fifo_mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;
  item_kind_t      kind;
  logic            keep;
  logic            push, pop;
  logic [EW-1:0]   head;

  // classify; the unused mode is taken and dropped
  always_comb begin
    case (in_tuser)
      MODE_SAMPLE: begin
        kind = KIND_SAMPLE;
        keep = 1'b1;
      end
      MODE_TRIGGER: begin
        kind = KIND_TRIGGER;
        keep = 1'b1;
      end
      MODE_RELEASE: begin
        kind = KIND_RELEASE;
        keep = 1'b1;
      end
      default: begin
        kind = KIND_SAMPLE;
        keep = 1'b0;
      end
    endcase
  end

  assign in_tready = count_r != (Q_AW + 1)'(Q_DEPTH);
  assign push      = in_tvalid && in_tready && keep;
  assign pop       = q_valid && q_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= {in_tlast, in_tdata[SAMPLE_WIDTH-1:0], kind};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  assign head     = fifo_mem[rd_ptr_r];
  assign q_valid  = count_r != '0;
  assign q_kind   = item_kind_t'(head[1:0]);
  assign q_sample = head[SAMPLE_WIDTH+1:2];
  assign q_eob    = head[EW-1];

  `AEG_ASSERT_NEXT(a_unused_dropped,
      in_tvalid && in_tready && in_tuser == MODE_UNUSED && !pop,
      count_r == $past(count_r))

endmodule

`default_nettype wire

>>> rtl/aeg_core.sv
// Back end: envelope phase, segment choice, gain and sample scaling.
`default_nettype none
`include "assert_macros.svh"

module aeg_core #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire aeg_pkg::env_cfg_t                 cfg,
  input  wire logic                              q_valid,
  output logic                                   q_ready,
  input  wire aeg_pkg::item_kind_t               q_kind,
  input  wire logic [SAMPLE_WIDTH-1:0]           q_sample,
  input  wire logic                              q_eob,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [aeg_pkg::OUT_TDATA_W-1:0]        out_tdata,  // sample_out, level, stage
  output logic                                   out_tlast   // end_of_block_out
);
  import aeg_pkg::*;

  localparam int F  = PHASE_FRAC_BITS;
  localparam int SW = SAMPLE_WIDTH;
  localparam int PW = SW + GAIN_W + 1;

  core_state_t              state_r, state_nxt;
  logic [PHASE_W-1:0]       phase_r, phase_nxt;
  logic                     hold_r, hold_nxt;
  logic signed [SW-1:0]     sample_r;
  logic                     eob_r;
  logic [2:0]               stage_r, stage_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic [PHASE_W-1:0]       x_r, x_nxt;
  logic [GAIN_W-1:0]        k_r, k_nxt;
  logic [LEN_W-1:0]         den_r, den_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic                     out_valid_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic                     out_last_r;

  logic                     pop, div_start, load_out, out_free, ramp;
  logic [PHASE_W:0]         phase_sum;
  logic [PHASE_W-1:0]       phase_adv;
  logic [PHASE_W-1:0]       pint;
  logic [PHASE_W-1:0]       base_a, base_s;
  logic [PHASE_W+GAIN_W-1:0] mul_full;
  logic [NUM_W-1:0]         div_num;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quo;
  logic signed [PW-1:0]     y_full;
  logic [SW-1:0]            y_low;
  logic [GAIN_W-1:0]        y_out;

  assign out_free = !out_valid_r || out_tready;

  // saturating phase advance
  always_comb begin
    phase_sum = {1'b0, phase_r} + (PHASE_W + 1)'(cfg.phase_step);
    phase_adv = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
  end

  // segment boundaries compare on the integer part of the phase
  always_comb begin
    pint   = PHASE_W'(phase_r >> F);
    base_a = PHASE_W'(48'(cfg.bnd_a) << F);
    base_s = PHASE_W'(48'(cfg.bnd_s) << F);
  end

  // segment choice
  always_comb begin
    stage_nxt = STAGE_FINISHED;
    gain_nxt  = '0;
    x_nxt     = phase_r;
    k_nxt     = GAIN_ONE;
    den_nxt   = cfg.attack_len;
    ramp      = 1'b0;
    if (pint >= PHASE_W'(cfg.bnd_r)) begin
      stage_nxt = STAGE_FINISHED;
    end else if (pint < PHASE_W'(cfg.bnd_a)) begin
      stage_nxt = STAGE_ATTACK;
      ramp      = 1'b1;
    end else if (pint < PHASE_W'(cfg.bnd_d)) begin
      stage_nxt = STAGE_DECAY;
      x_nxt     = phase_r - base_a;
      k_nxt     = GAIN_DECAY_DROP;
      den_nxt   = cfg.decay_len;
      ramp      = 1'b1;
    end else if (pint < PHASE_W'(cfg.bnd_s) || hold_r) begin
      stage_nxt = STAGE_SUSTAIN;
      gain_nxt  = GAIN_SUSTAIN;
    end else begin
      stage_nxt = STAGE_RELEASE;
      x_nxt     = phase_r - base_s;
      k_nxt     = GAIN_SUSTAIN;
      den_nxt   = cfg.release_len;
      ramp      = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid && q_kind == KIND_SAMPLE) state_nxt = ST_SEG;
      ST_SEG:   state_nxt = ramp ? ST_MUL : ST_SCALE;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV:   if (div_done) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_ready   = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: q_ready   = 1'b1;
      ST_MUL:  div_start = 1'b1;
      ST_OUT:  load_out  = out_free;
      default: ;
    endcase
  end

  assign pop = q_valid && q_ready;

  // envelope state updates
  always_comb begin
    phase_nxt = phase_r;
    hold_nxt  = hold_r;
    if (pop) begin
      case (q_kind)
        KIND_TRIGGER: begin
          phase_nxt = '0;
          hold_nxt  = 1'b1;
        end
        KIND_RELEASE: hold_nxt  = 1'b0;
        default:      phase_nxt = phase_adv;
      endcase
    end else if (state_r == ST_SEG && hold_r && pint >= PHASE_W'(cfg.bnd_s)
                 && pint < PHASE_W'(cfg.bnd_r)) begin
      // held: the phase parks at the sustain end
      phase_nxt = base_s;
    end
  end

  // ramp numerator: offset times slope height, fraction bits dropped
  always_comb begin
    mul_full = (PHASE_W + GAIN_W)'(x_r) * (PHASE_W + GAIN_W)'(k_r);
    div_num  = NUM_W'(mul_full >> F);
  end

  aeg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sample scaling, floor by arithmetic shift
  always_comb begin
    prod_nxt = sample_r * $signed({1'b0, gain_r});
    y_full   = prod_r >>> 15;
    y_low    = y_full[SW-1:0];
    y_out    = GAIN_W'(32'(y_low));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '1;
      hold_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      hold_r  <= hold_nxt;
      if (load_out)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      sample_r <= q_sample;
      eob_r    <= q_eob;
    end
    if (state_r == ST_SEG) begin
      stage_r <= stage_nxt;
      gain_r  <= gain_nxt;
      x_r     <= x_nxt;
      k_r     <= k_nxt;
      den_r   <= den_nxt;
    end
    if (state_r == ST_DIV && div_done) begin
      case (stage_r)
        STAGE_ATTACK: gain_r <= GAIN_W'(div_quo);
        STAGE_DECAY:  gain_r <= GAIN_ONE - GAIN_W'(div_quo);
        default:      gain_r <= GAIN_SUSTAIN - GAIN_W'(div_quo);
      endcase
    end
    if (state_r == ST_SCALE) begin
      prod_r <= prod_nxt;
    end
    if (load_out) begin
      out_data_r <= {5'b0, stage_r, gain_r, y_out};
      out_last_r <= eob_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `AEG_ASSERT_IMP(a_finished_silent,
      state_r == ST_OUT && stage_r == STAGE_FINISHED, gain_r == '0)
  `AEG_ASSERT_IMP(a_div_only_ramps,
      div_start, stage_r == STAGE_ATTACK || stage_r == STAGE_DECAY ||
      stage_r == STAGE_RELEASE)
  `AEG_ASSERT_NEXT(a_trigger_restarts,
      pop && q_kind == KIND_TRIGGER, phase_r == '0 && hold_r)

endmodule

`default_nettype wire

>>> rtl/adsr_envelope_gain_unit.sv
// Top level: settings registers, front queue and envelope back end.
// Trigger and release items are taken while the back end is idle and give no result.
// A ramp sample (attack, decay, release) runs the back end through SEG, MUL, DIV, SCALE and OUT,
// waiting in DIV for the 15-step serial divider; a flat sample (sustain, finished) skips MUL and DIV.
// The back end takes a new item only when idle; a 4-item queue keeps input open until it fills.
// rst_n (synchronous, low) empties the queue, sets the phase to all ones (finished),
// clears hold and restores the register defaults.
`default_nettype none

module adsr_envelope_gain_unit #(
  parameter  int SAMPLE_WIDTH    = 16,
  parameter  int PHASE_FRAC_BITS = 16,
  localparam int IN_TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [aeg_pkg::CFG_IDX_W-1:0]         cfg_addr,
  input  wire logic [aeg_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [IN_TDATA_W-1:0]                 in_tdata,   // sample_in
  input  wire logic [1:0]                            in_tuser,   // mode
  input  wire logic                                  in_tlast,   // end_of_block
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [aeg_pkg::OUT_TDATA_W-1:0]            out_tdata,  // sample_out, level, stage
  output logic                                       out_tlast   // end_of_block_out
);
  import aeg_pkg::*;

  logic [LEN_W-1:0]    attack_r, decay_r, sustain_r, release_r;
  logic [STEP_W-1:0]   step_r;
  logic [BND_W-1:0]    bnd_a_r, bnd_d_r, bnd_s_r, bnd_r_r;
  env_cfg_t            cfg;
  logic                q_valid, q_ready, q_eob;
  item_kind_t          q_kind;
  logic [SAMPLE_WIDTH-1:0] q_sample;

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= LEN_RESET;
      decay_r   <= LEN_RESET;
      sustain_r <= LEN_RESET;
      release_r <= LEN_RESET;
      step_r    <= STEP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ATTACK:  attack_r  <= cfg_wdata[LEN_W-1:0];
        REG_DECAY:   decay_r   <= cfg_wdata[LEN_W-1:0];
        REG_SUSTAIN: sustain_r <= cfg_wdata[LEN_W-1:0];
        REG_RELEASE: release_r <= cfg_wdata[LEN_W-1:0];
        REG_STEP:    step_r    <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // segment ends in whole phase units, registered from the settings
  always_ff @(posedge clk) begin
    bnd_a_r <= BND_W'(attack_r);
    bnd_d_r <= BND_W'(attack_r) + BND_W'(decay_r);
    bnd_s_r <= BND_W'(attack_r) + BND_W'(decay_r) + BND_W'(sustain_r);
    bnd_r_r <= BND_W'(attack_r) + BND_W'(decay_r) + BND_W'(sustain_r)
             + BND_W'(release_r);
  end

  always_comb begin
    cfg.attack_len  = attack_r;
    cfg.decay_len   = decay_r;
    cfg.release_len = release_r;
    cfg.phase_step  = step_r;
    cfg.bnd_a       = bnd_a_r;
    cfg.bnd_d       = bnd_d_r;
    cfg.bnd_s       = bnd_s_r;
    cfg.bnd_r       = bnd_r_r;
  end

  aeg_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_kind    (q_kind),
    .q_sample  (q_sample),
    .q_eob     (q_eob)
  );

  aeg_core #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .PHASE_FRAC_BITS (PHASE_FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_kind     (q_kind),
    .q_sample   (q_sample),
    .q_eob      (q_eob),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> tb/sv/adsr_envelope_checker.sv
// Checker for the envelope gain unit: tracks settings and items, predicts and compares results.
`timescale 1ns / 1ps

module adsr_envelope_checker #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [aeg_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [aeg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  input  wire logic [15:0]                       in_tdata,   // sample_in
  input  wire logic [1:0]                        in_tuser,   // mode
  input  wire logic                              in_tlast,   // end_of_block
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [aeg_pkg::OUT_TDATA_W-1:0]   out_tdata,  // sample_out, level, stage
  input  wire logic                              out_tlast,  // end_of_block_out
  output int                                     fails,
  output int                                     pending
);
  import aeg_pkg::*;

  localparam int REPORT_MAX = 40;

  typedef struct {
    logic [15:0] sample_out;
    logic [15:0] level;
    logic [2:0]  stage;
    logic        last;
  } scaled_item_t;

  // Shadow settings and envelope state
  logic [LEN_W-1:0]   atk_len, dec_len, sus_len, rel_len;
  logic [STEP_W-1:0]  step;
  logic [PHASE_W-1:0] phase;
  logic               held;

  // Scaled samples still owed by the block, oldest first
  scaled_item_t results_due[$];

  initial begin
    fails = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fails < REPORT_MAX) $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fails++;
  endtask

  // Advance the phase by one sample and work out gain, stage and scaled sample
  function automatic scaled_item_t envelope_gain_step(input logic [15:0] smp, input logic eob);
    logic [63:0]  b_a, b_d, b_s, b_r, ph, q;
    logic [15:0]  gain;
    logic [2:0]   stg;
    longint       prod;
    scaled_item_t res;
    b_a = 64'(atk_len) << FRAC_BITS;
    b_d = b_a + (64'(dec_len) << FRAC_BITS);
    b_s = b_d + (64'(sus_len) << FRAC_BITS);
    b_r = b_s + (64'(rel_len) << FRAC_BITS);
    // saturating accumulate
    ph = 64'(phase) + 64'(step);
    if (ph > 64'hFFFF_FFFF) ph = 64'hFFFF_FFFF;
    phase = ph[PHASE_W-1:0];
    // finished is checked first, even while held
    if (ph >= b_r) begin
      gain = '0;
      stg = STAGE_FINISHED;
    end else if (ph < b_a) begin
      q = (ph * 64'(GAIN_ONE)) / b_a;
      gain = q[15:0];
      stg = STAGE_ATTACK;
    end else if (ph < b_d) begin
      q = ((ph - b_a) * 64'(GAIN_DECAY_DROP)) / (b_d - b_a);
      gain = GAIN_ONE - q[15:0];
      stg = STAGE_DECAY;
    end else if (ph < b_s) begin
      gain = GAIN_SUSTAIN;
      stg = STAGE_SUSTAIN;
    end else if (held) begin
      phase = b_s[PHASE_W-1:0];
      gain = GAIN_SUSTAIN;
      stg = STAGE_SUSTAIN;
    end else begin
      q = ((ph - b_s) * 64'(GAIN_SUSTAIN)) / (b_r - b_s);
      gain = GAIN_SUSTAIN - q[15:0];
      stg = STAGE_RELEASE;
    end
    // truncating product: arithmetic shift floors
    prod = longint'($signed(smp)) * longint'({48'd0, gain});
    prod = prod >>> 15;
    res.sample_out = prod[15:0];
    res.level = gain;
    res.stage = stg;
    res.last = eob;
    return res;
  endfunction

  always @(posedge clk) begin
    scaled_item_t want;
    if (!rst_n) begin
      atk_len = LEN_RESET;
      dec_len = LEN_RESET;
      sus_len = LEN_RESET;
      rel_len = LEN_RESET;
      step = STEP_RESET;
      phase = '1;
      held = 1'b0;
      results_due.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_ATTACK:  atk_len = cfg_wdata[LEN_W-1:0];
          REG_DECAY:   dec_len = cfg_wdata[LEN_W-1:0];
          REG_SUSTAIN: sus_len = cfg_wdata[LEN_W-1:0];
          REG_RELEASE: rel_len = cfg_wdata[LEN_W-1:0];
          REG_STEP:    step = cfg_wdata[STEP_W-1:0];
          default: ;
        endcase
      end
      // results against the oldest expectation
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due, sample_out",
                          $signed(out_tdata[15:0]), 0);
        end else begin
          want = results_due.pop_front();
          if (out_tdata[15:0] !== want.sample_out)
            report_mismatch("sample_out", $signed(out_tdata[15:0]), $signed(want.sample_out));
          if (out_tdata[31:16] !== want.level)
            report_mismatch("level", out_tdata[31:16], want.level);
          if (out_tdata[34:32] !== want.stage)
            report_mismatch("stage", out_tdata[34:32], want.stage);
          if (out_tdata[39:35] !== '0)
            report_mismatch("tdata pad", out_tdata[39:35], 0);
          if (out_tlast !== want.last)
            report_mismatch("end_of_block_out", out_tlast, want.last);
        end
      end
      // accepted items
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_SAMPLE:  results_due.push_back(envelope_gain_step(in_tdata, in_tlast));
          MODE_TRIGGER: begin
            phase = '0;
            held = 1'b1;
          end
          MODE_RELEASE: held = 1'b0;
          default: ;
        endcase
      end
    end
    pending = results_due.size();
  end

endmodule

>>> tb/sv/tb_adsr_envelope_gain_unit.sv
// Testbench top: drives items and settings into the envelope gain unit and gives the verdict.
`timescale 1ns / 1ps

module tb_adsr_envelope_gain_unit;
  import aeg_pkg::*;

  localparam int SMP_W           = 16;
  localparam int PRESSURE_AFTER  = 150;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 60;
  localparam int MAX_STEP        = 24'hFF_FFFF;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SMP_W-1:0]      in_tdata  = '0;          // sample_in
  logic [1:0]            in_tuser  = MODE_SAMPLE;  // mode
  logic                  in_tlast  = 1'b0;        // end_of_block
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;              // sample_out, level, stage
  logic                  out_tlast;               // end_of_block_out

  int fails;
  int pending;
  int rx_count = 0;
  bit in_steady = 1'b0;

  always #5 clk = ~clk;

  adsr_envelope_gain_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  adsr_envelope_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fails      (fails),
    .pending    (pending)
  );

  // Offer one item, after a random gap unless in steady mode, and hold it until accepted
  task automatic send_item(input logic [1:0] mode, input logic [SMP_W-1:0] smp,
                           input logic eob);
    int gap;
    int r;
    gap = 0;
    if (!in_steady) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 4);
      else if (r < 98) gap = $urandom_range(5, 20);
      else gap = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = mode;
    in_tdata = smp;
    in_tlast = eob;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Write all five registers, one per cycle
  task automatic configure(input int atk, input int dec, input int sus, input int rel,
                           input int stp);
    logic [CFG_IDX_W-1:0] idx [5];
    int val [5];
    idx = '{REG_ATTACK, REG_DECAY, REG_SUSTAIN, REG_RELEASE, REG_STEP};
    val = '{atk, dec, sus, rel, stp};
    for (int i = 0; i < 5; i++) begin
      cfg_wr_en = 1'b1;
      cfg_addr = idx[i];
      cfg_wdata = CFG_DATA_W'(val[i]);
      @(negedge clk);
    end
    cfg_wr_en = 1'b0;
  endtask

  // Drain: every result in, then let trailing no-result items finish
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Segment length, biased to short segments and the range ends
  function automatic int rand_len(input int lo);
    case ($urandom_range(0, 9))
      0: return lo;
      1: return 10000;
      2, 3, 4, 5: return $urandom_range(lo, 300);
      default: return $urandom_range(lo, 10000);
    endcase
  endfunction

  // Receiver: random stalls, free-running stretches, one long hold-off
  initial begin
    int stall_left;
    int free_left;
    int r;
    bit pressed;
    stall_left = 0;
    free_left = 0;
    pressed = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (!pressed && rx_count >= PRESSURE_AFTER) begin
        pressed = 1'b1;
        out_tready = 1'b0;
        stall_left = PRESSURE_CYCLES - 1;
      end else if (free_left > 0) begin
        out_tready = 1'b1;
        free_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          free_left = $urandom_range(50, 200);
          out_tready = 1'b1;
        end else if (r < 70) begin
          out_tready = 1'b1;
        end else if (r < 96) begin
          out_tready = 1'b0;
          stall_left = $urandom_range(0, 3);
        end else begin
          out_tready = 1'b0;
          stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) rx_count <= rx_count + 1;
  end

  // Stimulus
  initial begin
    int a, d, s, r, stp, budget, est, n;
    longint span;
    logic [1:0] mode_pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: phase starts saturated, so first samples are finished
    send_item(MODE_SAMPLE, 16'h7FFF, 1'b1);
    send_item(MODE_SAMPLE, 16'h8000, 1'b0);
    send_item(MODE_UNUSED, 16'h1234, 1'b1);
    send_item(MODE_TRIGGER, 16'h0000, 1'b0);
    send_item(MODE_SAMPLE, 16'h7FFF, 1'b0);
    send_item(MODE_SAMPLE, 16'h8000, 1'b1);
    send_item(MODE_SAMPLE, 16'hFFFF, 1'b0);
    send_item(MODE_SAMPLE, 16'h0000, 1'b0);
    wait_idle();

    // Attack below ten, empty sustain, half-unit steps: hold clamps, then release
    configure(1, 2, 0, 3, 32768);
    send_item(MODE_TRIGGER, 16'hFFFF, 1'b1);
    for (n = 0; n < 7; n++) send_item(MODE_SAMPLE, n[0] ? 16'h7FFF : 16'h8000, n == 6);
    send_item(MODE_RELEASE, 16'hFFFF, 1'b0);
    repeat (6) send_item(MODE_SAMPLE, rand_sample(), 1'b0);
    wait_idle();

    // Random phases: mostly whole notes, some stray items
    for (int k = 0; k < 10; k++) begin
      case (k)
        0: begin
          a = 10; d = 0; s = 10000; r = 10000; stp = MAX_STEP; budget = 200;
        end
        1: begin
          a = 10000; d = 10000; s = 0; r = 0; stp = MAX_STEP; budget = 200;
        end
        2: begin
          a = rand_len(10); d = rand_len(0); s = rand_len(0); r = rand_len(0);
          stp = 0; budget = 30;
        end
        default: begin
          a = rand_len(10); d = rand_len(0); s = rand_len(0); r = rand_len(0);
          span = longint'(a + d + s + r) * 65536 / $urandom_range(12, 60);
          if (span > MAX_STEP) span = MAX_STEP;
          if (span < 1) span = 1;
          stp = int'(span);
          budget = 160;
        end
      endcase
      in_steady = ($urandom_range(0, 3) == 0);
      configure(a, d, s, r, stp);
      while (budget > 0) begin
        if ($urandom_range(0, 9) < 8) begin
          send_item(MODE_TRIGGER, SMP_W'($urandom), 1'($urandom));
          span = (stp == 0) ? 40 : longint'(a + d + s) * 65536 / stp + 1;
          est = (span > 80) ? 80 : int'(span);
          n = $urandom_range(1, est + 8);
          repeat (n) send_item(MODE_SAMPLE, rand_sample(), $urandom_range(0, 7) == 0);
          budget -= n + 1;
          if ($urandom_range(0, 9) != 0) begin
            send_item(MODE_RELEASE, SMP_W'($urandom), 1'($urandom));
            budget--;
          end
          span = (stp == 0) ? 10 : longint'(r) * 65536 / stp + 1;
          est = (span > 40) ? 40 : int'(span);
          n = $urandom_range(0, est + 4);
          repeat (n) send_item(MODE_SAMPLE, rand_sample(), $urandom_range(0, 7) == 0);
          budget -= n;
        end else begin
          mode_pick = 2'($urandom_range(0, 3));
          send_item(mode_pick, rand_sample(), 1'($urandom));
          if (mode_pick != MODE_UNUSED) budget--;
        end
      end
      wait_idle();
    end

    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> adsr_envelope_gain_unit.f
+incdir+rtl
rtl/aeg_pkg.sv
rtl/aeg_div.sv
rtl/aeg_front.sv
rtl/aeg_core.sv
rtl/adsr_envelope_gain_unit.sv
tb/sv/adsr_envelope_checker.sv
tb/sv/tb_adsr_envelope_gain_unit.sv
